### hw/rtl/repeat_purity_local_alignment_top_assert.svh
// Assertion macros for the repeat purity scorer.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef REPEAT_PURITY_LOCAL_ALIGNMENT_TOP_ASSERT_SVH
`define REPEAT_PURITY_LOCAL_ALIGNMENT_TOP_ASSERT_SVH

// consequent holds in the same cycle
`define RPLA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpla assertion failed");

// consequent holds in the next cycle
`define RPLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpla assertion failed");

`endif

### hw/rtl/rpla_pkg.sv
// Shared types, constants and helpers for the repeat purity scorer.
// No dependencies; used by every rpla module.
package rpla_pkg;

    localparam int MAX_PURE_DEF  = 256;
    localparam int MAX_MOTIF_DEF = 8;
    localparam int SCORE_W       = 10;
    localparam int SCORE_MAX     = 1023;
    localparam int MATCH_SC      = 2;
    localparam int MISMATCH_PEN  = 7;
    localparam int GAP_PEN       = 7;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CODED_BASES   = 8;

    typedef logic [2:0] t_base;

    localparam t_base BASE_N = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTIF_BASES  = 2'd0,
        CFG_MOTIF_LENGTH = 2'd1,
        CFG_REPEAT_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic  valid;
        logic  last;
        t_base base;
    } t_tok;

    typedef struct packed {
        logic  active;
        t_base base;
    } t_ideal;

    typedef struct packed {
        logic adv;
        logic load;
    } t_ctl;

    function automatic t_base norm_base(input t_base code);
        return (code > BASE_N) ? BASE_N : code;
    endfunction

endpackage

### hw/rtl/rpla_cell.sv
// One alignment cell: holds one ideal base and its column score.
// Depends on rpla_pkg.
module rpla_cell #(
    parameter int H_W = rpla_pkg::SCORE_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpla_pkg::t_ctl      i_ctl,
    input  rpla_pkg::t_tok      i_tok,
    input  logic [H_W-1:0]      i_up,
    input  logic [H_W-1:0]      i_diag,
    input  logic [H_W-1:0]      i_best,
    input  rpla_pkg::t_ideal    i_ideal,
    output rpla_pkg::t_tok      o_tok,
    output logic [H_W-1:0]      o_h,
    output logic [H_W-1:0]      o_diag,
    output logic [H_W-1:0]      o_best,
    output rpla_pkg::t_ideal    o_ideal
);

    logic             r_valid;
    logic             r_last;
    rpla_pkg::t_base  r_base;
    logic [H_W-1:0]   r_h;
    logic [H_W-1:0]   r_diag;
    logic [H_W-1:0]   r_best;
    logic [H_W-1:0]   r_col;
    logic [H_W-1:0]   r_max;
    rpla_pkg::t_ideal r_ideal;

    logic [H_W-1:0]   w_diag_sc;
    logic [H_W-1:0]   w_left_sc;
    logic [H_W-1:0]   w_up_sc;
    logic [H_W-1:0]   w_h;
    logic [H_W-1:0]   w_max;

    localparam logic [H_W-1:0] MATCH = H_W'(rpla_pkg::MATCH_SC);
    localparam logic [H_W-1:0] MISM  = H_W'(rpla_pkg::MISMATCH_PEN);
    localparam logic [H_W-1:0] GAP   = H_W'(rpla_pkg::GAP_PEN);

    always_comb begin
        if (r_ideal.base == i_tok.base) begin
            w_diag_sc = i_diag + MATCH;
        end else begin
            w_diag_sc = (i_diag >= MISM) ? i_diag - MISM : '0;
        end
        w_left_sc = (r_col >= GAP) ? r_col - GAP : '0;
        w_up_sc   = (i_up >= GAP) ? i_up - GAP : '0;
        w_h = w_diag_sc;
        if (w_left_sc > w_h) begin
            w_h = w_left_sc;
        end
        if (w_up_sc > w_h) begin
            w_h = w_up_sc;
        end
        if (!r_ideal.active) begin
            w_h = '0;
        end
        w_max = (w_h > r_max) ? w_h : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ideal <= i_ideal;
            r_col   <= '0;
            r_max   <= '0;
        end else if (i_ctl.adv) begin
            r_last <= i_tok.last;
            r_base <= i_tok.base;
            if (i_tok.valid) begin
                r_h    <= w_h;
                r_diag <= r_col;
                r_col  <= i_tok.last ? '0 : w_h;
                r_max  <= i_tok.last ? '0 : w_max;
                r_best <= (i_best > w_max) ? i_best : w_max;
            end
        end
    end

    assign o_tok   = '{valid: r_valid, last: r_last, base: r_base};
    assign o_h     = r_h;
    assign o_diag  = r_diag;
    assign o_best  = r_best;
    assign o_ideal = r_ideal;

endmodule

### hw/rtl/rpla_load.sv
// Configuration registers and ideal sequence loader for the cell row.
// Depends on rpla_pkg; feeds one ideal base per cycle into the row.
module rpla_load #(
    parameter int MAX_PURE  = rpla_pkg::MAX_PURE_DEF,
    parameter int MAX_MOTIF = rpla_pkg::MAX_MOTIF_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpla_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rpla_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rpla_pkg::t_ideal                  o_ideal,
    output logic                              o_busy,
    output logic                              o_clamped
);

    localparam int LEN_W = $clog2(MAX_MOTIF + 1);
    localparam int CNT_W = $clog2(MAX_PURE);
    localparam int TOT_W = 9 + LEN_W + 1;
    localparam int PUR_W = $clog2(MAX_PURE + 1) + 1;
    localparam int CMP_W = (TOT_W > PUR_W) ? TOT_W : PUR_W;

    logic [23:0]      r_motif;
    logic [3:0]       r_mlen;
    logic [15:0]      r_count;
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_mod;

    logic [LEN_W-1:0]   w_len;
    logic [8:0]         w_whole;
    logic [8+LEN_W:0]   w_tail_sum;
    logic [LEN_W-1:0]   w_tail;
    logic [CMP_W-1:0]   w_total;
    logic [4:0]         w_mod_ext;
    rpla_pkg::t_base    w_code;
    rpla_pkg::t_base    w_motif [rpla_pkg::CODED_BASES];
    logic               w_restart;

    always_comb begin
        w_len = (int'(r_mlen) > MAX_MOTIF) ? LEN_W'(MAX_MOTIF) : LEN_W'(r_mlen);
        w_whole = {1'b0, r_count[15:8]} + 9'd1;
        w_tail_sum = (9+LEN_W)'(r_count[7:0]) * (9+LEN_W)'(w_len) + (9+LEN_W)'(128);
        w_tail = (r_count[7:0] != 8'd0) ? LEN_W'(w_tail_sum >> 8) : '0;
        w_total = CMP_W'(w_whole) * CMP_W'(w_len) + CMP_W'(w_tail);
        for (int k = 0; k < rpla_pkg::CODED_BASES; k++) begin
            w_motif[k] = rpla_pkg::norm_base(r_motif[3*k +: 3]);
        end
        w_mod_ext = 5'(r_mod);
        w_code = (w_mod_ext < 5'(rpla_pkg::CODED_BASES)) ? w_motif[w_mod_ext[2:0]] : 3'd0;
    end

    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (rpla_pkg::t_cfg_idx'(i_cfg_idx))
                rpla_pkg::CFG_MOTIF_BASES,
                rpla_pkg::CFG_MOTIF_LENGTH,
                rpla_pkg::CFG_REPEAT_COUNT: w_restart = 1'b1;
                default:                    w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif <= '0;
            r_mlen  <= 4'd1;
            r_count <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (rpla_pkg::t_cfg_idx'(i_cfg_idx))
                rpla_pkg::CFG_MOTIF_BASES:  r_motif <= i_cfg_data;
                rpla_pkg::CFG_MOTIF_LENGTH: r_mlen  <= i_cfg_data[3:0];
                rpla_pkg::CFG_REPEAT_COUNT: r_count <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_mod  <= '0;
        end else if (w_restart) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_mod  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(MAX_PURE - 1)) begin
                r_busy <= 1'b0;
            end
            r_mod <= ((5'(r_mod) + 5'd1) >= 5'(w_len)) ? '0 : r_mod + LEN_W'(1);
        end
    end

    assign o_ideal   = '{active: (CMP_W'(r_cnt) < w_total), base: w_code};
    assign o_busy    = r_busy;
    assign o_clamped = w_total > CMP_W'(MAX_PURE);

endmodule

### hw/rtl/repeat_purity_local_alignment_top.sv
// Repeat purity scorer: top level with the alignment cell row and output register.
// Depends on rpla_pkg, rpla_load, rpla_cell and the assertion macro header.
//
// Use: write motif_bases (0), motif_length (1) and repeat_count (2) on the
// config port while idle, then stream observed bases on the s_ channel, one
// word per base, with s_tlast on the final base of a record. Each record gives
// one word on the m_ channel: the best local alignment score and the clamp flag.
// Throughput: one base per cycle unless the row is held or loading; each base steps
// through the MAX_PURE row cells, one cell per cycle, each holding one ideal base.
// The last base passes every cell register, then the output register, to m_tvalid.
// A new record may follow the last base in the next cycle.
// Reset and each write to motif_bases, motif_length or repeat_count start a load
// pass that shifts the ideal sequence into the row and clears each cell's column
// score and running maximum; s_tready is low during the pass.
// When the receiver stalls with a result held, the whole row holds and
// s_tready drops until the result is taken.
`include "repeat_purity_local_alignment_top_assert.svh"

module repeat_purity_local_alignment_top #(
    parameter int MAX_PURE  = rpla_pkg::MAX_PURE_DEF,
    parameter int MAX_MOTIF = rpla_pkg::MAX_MOTIF_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rpla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [2:0] base, [7:3] zero
    input  logic                            s_tlast,   // last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // [9:0] score, [10] pure_clamped
);

    localparam int H_W   = $clog2(2 * MAX_PURE + 1);
    localparam int SAT_W = (H_W > rpla_pkg::SCORE_W) ? H_W : rpla_pkg::SCORE_W;

    rpla_pkg::t_ctl   w_ctl;
    rpla_pkg::t_ideal w_load_ideal;
    logic             w_busy;
    logic             w_clamped;

    rpla_pkg::t_tok   w_tok   [MAX_PURE+1];
    logic [H_W-1:0]   w_h     [MAX_PURE+1];
    logic [H_W-1:0]   w_diag  [MAX_PURE+1];
    logic [H_W-1:0]   w_best  [MAX_PURE+1];
    rpla_pkg::t_ideal w_ideal [MAX_PURE+1];

    logic                         r_m_valid;
    logic [rpla_pkg::SCORE_W-1:0] r_score;
    logic                         r_clamped;
    logic [SAT_W-1:0]             w_best_ext;
    logic                         w_end_result;

    rpla_load #(
        .MAX_PURE  (MAX_PURE),
        .MAX_MOTIF (MAX_MOTIF)
    ) u_load (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ideal    (w_load_ideal),
        .o_busy     (w_busy),
        .o_clamped  (w_clamped)
    );

    assign w_ctl      = '{adv: !r_m_valid || m_tready, load: w_busy};
    assign s_tready   = w_ctl.adv && !w_busy;

    assign w_tok[0]   = '{valid: s_tvalid && s_tready, last: s_tlast,
                          base: rpla_pkg::norm_base(s_tdata[2:0])};
    assign w_h[0]     = '0;
    assign w_diag[0]  = '0;
    assign w_best[0]  = '0;
    assign w_ideal[MAX_PURE] = w_load_ideal;

    for (genvar g = 0; g < MAX_PURE; g++) begin : g_cell
        rpla_cell #(
            .H_W (H_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[g]),
            .i_up    (w_h[g]),
            .i_diag  (w_diag[g]),
            .i_best  (w_best[g]),
            .i_ideal (w_ideal[g+1]),
            .o_tok   (w_tok[g+1]),
            .o_h     (w_h[g+1]),
            .o_diag  (w_diag[g+1]),
            .o_best  (w_best[g+1]),
            .o_ideal (w_ideal[g])
        );
    end

    assign w_end_result = w_tok[MAX_PURE].valid && w_tok[MAX_PURE].last;
    assign w_best_ext   = SAT_W'(w_best[MAX_PURE]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.adv) begin
            r_m_valid <= w_end_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.adv && w_end_result) begin
            r_score   <= (w_best_ext > SAT_W'(rpla_pkg::SCORE_MAX))
                       ? rpla_pkg::SCORE_W'(rpla_pkg::SCORE_MAX)
                       : rpla_pkg::SCORE_W'(w_best_ext);
            r_clamped <= w_clamped;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {5'd0, r_clamped, r_score};

    `RPLA_ASSERT_NOW(a_no_input_during_load, w_busy, !s_tready)
    `RPLA_ASSERT_NOW(a_result_from_last, $rose(r_m_valid), $past(w_end_result))
    `RPLA_ASSERT_NEXT(a_cfg_starts_load,
        i_cfg_we && (i_cfg_idx == rpla_pkg::CFG_MOTIF_BASES ||
        i_cfg_idx == rpla_pkg::CFG_MOTIF_LENGTH ||
        i_cfg_idx == rpla_pkg::CFG_REPEAT_COUNT), w_busy)

endmodule
